### rtl/core/barometer_temp_pressure_compensation_macros.svh
// Assertion macros shared by the barometric compensation checker.
// Needs no other file; include it by its bare name.
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BTPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BTPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/btpc_pkg.sv
// Shared widths, constants and register codes of the barometric compensation block.
// Has no dependencies; the top level and the checker import it.
package btpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 20;
  localparam int PRES_W  = 32;
  localparam int IDX_W   = 3;

  localparam int DT_W    = 25;
  localparam int TPROD_W = 42;
  localparam int DD_W    = 50;
  localparam int T2_W    = 19;
  localparam int OFF_W   = 40;
  localparam int SENS_W  = 38;
  localparam int SQ_W    = 35;
  localparam int CORR_W  = 38;
  localparam int SPLIT   = 19;
  localparam int PPLO_W  = RAW_W + SPLIT;
  localparam int PPHI_W  = RAW_W + 1 + SENS_W - SPLIT;
  localparam int PROD_W  = 63;
  localparam int DIFF_W  = 43;

  localparam int SH_TEMP = 23;
  localparam int SH_OFF  = 7;
  localparam int SH_SENS = 8;
  localparam int SH_T2   = 31;
  localparam int SH_PROD = 21;
  localparam int SH_PRES = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW = -20'sd1500;

  localparam int PIPE_LATENCY = 10;

  typedef enum logic [IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

endpackage

### rtl/core/barometer_temp_pressure_compensation.sv
// A pair taken with start while busy is low shows its result with done once it has
// passed all ten register stages. Throughput: one pair per cycle while busy is low;
// the sensitivity product is split in two partial products, summed one stage later.
// Results cannot be held off by the receiver; done is a one-cycle strobe.
// Synchronous reset clears the valid bits and the six calibration words; busy is
// high during reset and in the cycle after it.
module barometer_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         raw_temperature,
  input  logic [RAW_W-1:0]         raw_baro,
  output logic                     done,
  output logic signed [TEMP_W-1:0] temperature,
  output logic signed [PRES_W-1:0] pressure,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6;
  logic busy_q;
  logic accept;
  logic [PIPE_LATENCY-1:0] vld;

  // Stage registers
  logic signed [DT_W-1:0]    dt1;
  logic [RAW_W-1:0]          d1_1, d1_2, d1_3, d1_4, d1_5, d1_6;
  logic signed [TPROD_W-1:0] ptemp2, poff2, psens2;
  logic signed [DD_W-1:0]    pdd2;
  logic signed [TEMP_W-1:0]  temp3, temp4, temp5, temp6, temp7, temp8, temp9;
  logic signed [OFF_W-1:0]   off3, off4, off5, off6, off7, off8;
  logic signed [SENS_W-1:0]  sens3, sens4, sens5, sens6;
  logic [T2_W-1:0]           t2_3, t2_4;
  logic [SQ_W-1:0]           asq4, bsq4;
  logic                      corr4, deep4;
  logic [CORR_W-1:0]         off2_5, sens2_5;
  logic [PPLO_W-1:0]         pplo7;
  logic signed [PPHI_W-1:0]  pphi7;
  logic signed [PROD_W-1:0]  prod8;
  logic signed [DIFF_W-1:0]  diff9;

  // Combinational signals
  logic signed [TPROD_W-1:0] temp_bias, off_bias, sens_bias;
  logic signed [TPROD_W-1:0] temp_sum, off_sum, sens_sum;
  logic signed [TEMP_W-1:0]  a4, b4;
  logic signed [2*TEMP_W-1:0] a_sq, b_sq;
  logic [CORR_W-1:0]         asq_x, bsq_x, a5x, b7x, b11x;
  logic signed [PROD_W-1:0]  prod_bias, prod_sum, prod_q;
  logic signed [DIFF_W-1:0]  diff_bias, diff_sum, pres_q;
  logic [DIFF_W-PRES_W:0]    pres_hi;

  assign accept    = start && !busy;
  assign busy      = rst || busy_q;
  assign cfg_ready = 1'b1;
  assign done      = vld[PIPE_LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b1;
      vld    <= '0;
      c1     <= '0;
      c2     <= '0;
      c3     <= '0;
      c4     <= '0;
      c5     <= '0;
      c6     <= '0;
    end else begin
      busy_q <= 1'b0;
      vld    <= {vld[PIPE_LATENCY-2:0], accept};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_C1:  c1 <= cfg_data;
          REG_C2:  c2 <= cfg_data;
          REG_C3:  c3 <= cfg_data;
          REG_C4:  c4 <= cfg_data;
          REG_C5:  c5 <= cfg_data;
          REG_C6:  c6 <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    temp_bias = ptemp2[TPROD_W-1] ? $signed({{(TPROD_W-SH_TEMP){1'b0}}, {SH_TEMP{1'b1}}})
                                  : '0;
    off_bias  = poff2[TPROD_W-1] ? $signed({{(TPROD_W-SH_OFF){1'b0}}, {SH_OFF{1'b1}}})
                                 : '0;
    sens_bias = psens2[TPROD_W-1] ? $signed({{(TPROD_W-SH_SENS){1'b0}}, {SH_SENS{1'b1}}})
                                  : '0;
    temp_sum  = (ptemp2 + temp_bias) >>> SH_TEMP;
    off_sum   = (poff2 + off_bias) >>> SH_OFF;
    sens_sum  = (psens2 + sens_bias) >>> SH_SENS;

    a4   = temp3 - TEMP_REF;
    b4   = temp3 - TEMP_LOW;
    a_sq = a4 * a4;
    b_sq = b4 * b4;

    asq_x = CORR_W'(asq4);
    bsq_x = CORR_W'(bsq4);
    a5x   = (asq_x << 2) + asq_x;
    b7x   = (bsq_x << 3) - bsq_x;
    b11x  = (bsq_x << 3) + (bsq_x << 1) + bsq_x;

    prod_bias = prod8[PROD_W-1] ? $signed({{(PROD_W-SH_PROD){1'b0}}, {SH_PROD{1'b1}}})
                                : '0;
    prod_sum  = prod8 + prod_bias;
    prod_q    = prod_sum >>> SH_PROD;

    diff_bias = diff9[DIFF_W-1] ? $signed({{(DIFF_W-SH_PRES){1'b0}}, {SH_PRES{1'b1}}})
                                : '0;
    diff_sum  = diff9 + diff_bias;
    pres_q    = diff_sum >>> SH_PRES;
    pres_hi   = pres_q[DIFF_W-1:PRES_W-1];
  end

  always_ff @(posedge clk) begin
    // Stage 1: temperature difference against the reference.
    dt1  <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c5, 8'b0});
    d1_1 <= raw_baro;

    // Stage 2: first-order products.
    ptemp2 <= dt1 * $signed({1'b0, c6});
    poff2  <= dt1 * $signed({1'b0, c4});
    psens2 <= dt1 * $signed({1'b0, c3});
    pdd2   <= dt1 * dt1;
    d1_2   <= d1_1;

    // Stage 3: first-order temperature, offset and sensitivity.
    temp3 <= TEMP_W'(temp_sum) + TEMP_REF;
    off3  <= $signed({{(OFF_W-COEF_W-16){1'b0}}, c2, 16'b0}) + OFF_W'(off_sum);
    sens3 <= $signed({{(SENS_W-COEF_W-15){1'b0}}, c1, 15'b0}) + SENS_W'(sens_sum);
    t2_3  <= pdd2[DD_W-1:SH_T2];
    d1_3  <= d1_2;

    // Stage 4: squares of the distances from both temperature thresholds.
    asq4  <= a_sq[SQ_W-1:0];
    bsq4  <= b_sq[SQ_W-1:0];
    corr4 <= temp3 < TEMP_REF;
    deep4 <= temp3 < TEMP_LOW;
    temp4 <= temp3;
    off4  <= off3;
    sens4 <= sens3;
    t2_4  <= t2_3;
    d1_4  <= d1_3;

    // Stage 5: second-order correction terms.
    if (corr4) begin
      off2_5  <= (a5x >> 1) + (deep4 ? b7x : '0);
      sens2_5 <= (a5x >> 2) + (deep4 ? (b11x >> 1) : '0);
      temp5   <= temp4 - $signed(TEMP_W'(t2_4));
    end else begin
      off2_5  <= '0;
      sens2_5 <= '0;
      temp5   <= temp4;
    end
    off5  <= off4;
    sens5 <= sens4;
    d1_5  <= d1_4;

    // Stage 6: corrected offset and sensitivity.
    off6  <= off5 - $signed(OFF_W'(off2_5));
    sens6 <= sens5 - $signed(SENS_W'(sens2_5));
    temp6 <= temp5;
    d1_6  <= d1_5;

    // Stage 7: partial products of the raw pressure and the sensitivity.
    pplo7 <= PPLO_W'(d1_6) * PPLO_W'(sens6[SPLIT-1:0]);
    pphi7 <= $signed({1'b0, d1_6}) * $signed(sens6[SENS_W-1:SPLIT]);
    off7  <= off6;
    temp7 <= temp6;

    // Stage 8: full product.
    prod8 <= (PROD_W'(pphi7) <<< SPLIT) + $signed(PROD_W'(pplo7));
    off8  <= off7;
    temp8 <= temp7;

    // Stage 9: scaled product less the offset.
    diff9 <= DIFF_W'(prod_q) - DIFF_W'(off8);
    temp9 <= temp8;

    // Stage 10: final scaling and saturation.
    if ((&pres_hi) || !(|pres_hi)) begin
      pressure <= pres_q[PRES_W-1:0];
    end else if (pres_q[DIFF_W-1]) begin
      pressure <= {1'b1, {(PRES_W-1){1'b0}}};
    end else begin
      pressure <= {1'b0, {(PRES_W-1){1'b1}}};
    end
    temperature <= temp9;
  end

endmodule

### rtl/core/btpc_checker.sv
// Port-level checker for the barometric compensation block, bound to its top level.
// Depends on btpc_pkg and the shared assertion macros header.
`include "barometer_temp_pressure_compensation_macros.svh"

module btpc_checker
  import btpc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  `BTPC_ASSERT_IMP(a_done_follows, clk, rst, start && !busy, ##PIPE_LATENCY done, "accepted transfer gave no result")
  `BTPC_ASSERT_IMP(a_done_has_cause, clk, rst, done, $past(start && !busy, PIPE_LATENCY), "result without a matching transfer")
  `BTPC_ASSERT_NXT(a_busy_short, clk, rst, busy, !busy, "busy held beyond one cycle after reset")
  `BTPC_ASSERT_IMP(a_busy_quiet, clk, rst, busy, !done, "result shown while busy after reset")
  `BTPC_ASSERT_IMP(a_cfg_open, clk, rst, cfg_valid, cfg_ready, "configuration transfer refused")

endmodule

bind barometer_temp_pressure_compensation btpc_checker u_btpc_checker (.*);
